// ===== design/llap_pkg.sv =====
`timescale 1ns / 1ps

package llap_pkg;

	localparam int MAC_W   = 48;
	localparam int BYTE_W  = 8;
	localparam int SEQ_W   = 32;
	localparam int FLAG_W  = 7;
	localparam int ST_W    = 3;
	localparam int RSN_W   = 4;

	localparam int IN_TDATA_W  = 120;
	localparam int OUT_TDATA_W = 112;

	localparam logic [BYTE_W-1:0] PAY_CAP_RST = 8'd44;
	localparam logic [1:0]        PROTO_TAG   = 2'b10;
	localparam logic [MAC_W-1:0]  BCAST_MAC   = {MAC_W{1'b1}};

	// link flag bit positions
	localparam int FL_ENTL = 0;
	localparam int FL_ID_A = 1;
	localparam int FL_ID_B = 2;
	localparam int FL_SEND = 3;
	localparam int FL_BUSY = 4;
	localparam int FL_RECV = 5;
	localparam int FL_FULL = 6;

	typedef enum logic [ST_W-1:0] {
		ST_INIT    = 3'd0,
		ST_PING    = 3'd1,
		ST_PONG    = 3'd2,
		ST_GOT     = 3'd3,
		ST_ACK     = 3'd4,
		ST_ACKACK  = 3'd5,
		ST_PROCEED = 3'd6
	} proto_state_t;

	typedef enum logic [RSN_W-1:0] {
		RSN_NONE      = 4'd0,
		RSN_TAG       = 4'd1,
		RSN_LENGTH    = 4'd2,
		RSN_INIT_LEN  = 4'd3,
		RSN_SAME_MAC  = 4'd4,
		RSN_OVL_INIT  = 4'd5,
		RSN_ROLE      = 4'd6,
		RSN_OVL_PING  = 4'd7,
		RSN_PEER      = 4'd8,
		RSN_STATE     = 4'd9
	} drop_reason_t;

	typedef struct packed {
		logic              user_busy;
		logic              user_full;
		logic [BYTE_W-1:0] payload_len;
		logic [BYTE_W-1:0] proto_byte;
		logic [MAC_W-1:0]  src_mac;
		logic [MAC_W-1:0]  dst_mac;
	} item_t;

	typedef struct packed {
		logic              zero_payload;
		logic              release_inbound;
		logic              capture_inbound;
		logic              load_outbound;
		logic [MAC_W-1:0]  reply_dst_mac;
		logic [SEQ_W-1:0]  reply_seq;
		logic [BYTE_W-1:0] reply_len;
		logic [BYTE_W-1:0] reply_proto;
		logic [RSN_W-1:0]  drop_reason;
		logic              transmit;
	} result_t;

endpackage

// ===== design/llap_proto.sv =====
`timescale 1ns / 1ps

// Link protocol state and the per-frame decision. The result is combinational
// from the registered item; state commits on adv.
module llap_proto (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [llap_pkg::BYTE_W-1:0] cfg_data,
	input  logic                       adv,
	input  llap_pkg::item_t            item,
	output llap_pkg::result_t          result
);

	logic [llap_pkg::MAC_W-1:0]  peer_mac_q, peer_nx;
	logic [llap_pkg::ST_W-1:0]   own_q, own_nx;
	logic [llap_pkg::ST_W-1:0]   remote_q, remote_nx;
	logic [llap_pkg::BYTE_W-1:0] rlen_q, rlen_nx;
	logic [llap_pkg::SEQ_W-1:0]  seq_q, seq_nx, seq_inc;
	logic [llap_pkg::FLAG_W-1:0] flags_q, fl;
	logic [llap_pkg::BYTE_W-1:0] pay_cap_q;

	llap_pkg::drop_reason_t rsn;
	logic load, capture, release_i, ob_ok;

	always_comb begin
		peer_nx   = peer_mac_q;
		own_nx    = own_q;
		remote_nx = remote_q;
		rlen_nx   = rlen_q;
		seq_nx    = seq_q;
		fl        = flags_q;
		rsn       = llap_pkg::RSN_NONE;
		load      = 1'b0;
		capture   = 1'b0;
		release_i = 1'b0;
		ob_ok     = 1'b0;

		if (item.proto_byte[7:6] != llap_pkg::PROTO_TAG) begin
			rsn = llap_pkg::RSN_TAG;
		end else begin
			remote_nx = item.proto_byte[2:0];
			if (item.payload_len > pay_cap_q) begin
				rsn = llap_pkg::RSN_LENGTH;
			end else begin
				rlen_nx = '0;
				if (!fl[llap_pkg::FL_SEND] && fl[llap_pkg::FL_BUSY] && !item.user_full) begin
					fl[llap_pkg::FL_BUSY] = 1'b0;
				end
				if (item.user_busy && fl[llap_pkg::FL_RECV] && fl[llap_pkg::FL_FULL]) begin
					fl[llap_pkg::FL_FULL] = 1'b0;
					fl[llap_pkg::FL_RECV] = 1'b0;
				end
				// outbound attempt, shared by the ping/pong arms
				ob_ok = (item.user_full && !fl[llap_pkg::FL_BUSY]) || fl[llap_pkg::FL_SEND];

				unique case (item.proto_byte[5:0])
					{llap_pkg::ST_INIT, llap_pkg::ST_INIT}: begin
						if (item.payload_len != '0) begin
							rsn = llap_pkg::RSN_INIT_LEN;
						end else begin
							seq_nx = '0;
							fl     = '0;
							if (item.dst_mac == llap_pkg::BCAST_MAC) begin
								own_nx  = llap_pkg::ST_INIT;
								peer_nx = item.src_mac;
							end else if (item.dst_mac < item.src_mac) begin
								// never taken: flags were just cleared
								if (fl[llap_pkg::FL_ENTL]) begin
									rsn = llap_pkg::RSN_OVL_INIT;
								end else begin
									fl[llap_pkg::FL_ENTL] = 1'b1;
									fl[llap_pkg::FL_ID_B] = 1'b1;
									own_nx  = llap_pkg::ST_PING;
									peer_nx = item.src_mac;
								end
							end else if (item.dst_mac > item.src_mac) begin
								own_nx  = llap_pkg::ST_INIT;
								peer_nx = item.src_mac;
							end else begin
								rsn = llap_pkg::RSN_SAME_MAC;
							end
						end
					end
					{llap_pkg::ST_INIT, llap_pkg::ST_PING}: begin
						if (item.dst_mac < item.src_mac) begin
							rsn = llap_pkg::RSN_ROLE;
						end else if (fl[llap_pkg::FL_ENTL]) begin
							rsn = llap_pkg::RSN_OVL_PING;
						end else begin
							fl[llap_pkg::FL_ENTL] = 1'b1;
							fl[llap_pkg::FL_ID_A] = 1'b1;
							own_nx = llap_pkg::ST_PONG;
						end
					end
					{llap_pkg::ST_PROCEED, llap_pkg::ST_PING},
					{llap_pkg::ST_PONG, llap_pkg::ST_PING},
					{llap_pkg::ST_PROCEED, llap_pkg::ST_PONG},
					{llap_pkg::ST_PING, llap_pkg::ST_PONG}: begin
						if (peer_mac_q != item.src_mac) begin
							rsn = llap_pkg::RSN_PEER;
						end else if ((item.proto_byte[0] && !fl[llap_pkg::FL_ID_A]) ||
						             (!item.proto_byte[0] && !fl[llap_pkg::FL_ID_B])) begin
							// sender in Ping needs ID_A, sender in Pong needs ID_B
							rsn = llap_pkg::RSN_ROLE;
						end else if (ob_ok) begin
							if (!fl[llap_pkg::FL_BUSY]) begin
								fl[llap_pkg::FL_SEND] = 1'b1;
								fl[llap_pkg::FL_BUSY] = 1'b1;
							end
							rlen_nx = pay_cap_q;
							load    = 1'b1;
							own_nx  = llap_pkg::ST_GOT;
						end else begin
							own_nx = item.proto_byte[0] ? llap_pkg::ST_PONG : llap_pkg::ST_PING;
						end
					end
					{llap_pkg::ST_PING, llap_pkg::ST_GOT},
					{llap_pkg::ST_PONG, llap_pkg::ST_GOT}: begin
						if (!fl[llap_pkg::FL_RECV] && item.payload_len != '0) begin
							rlen_nx               = item.payload_len;
							fl[llap_pkg::FL_RECV] = 1'b1;
							capture               = 1'b1;
							own_nx                = llap_pkg::ST_ACK;
						end else begin
							rlen_nx = '0;
							own_nx  = item.proto_byte[4] ? llap_pkg::ST_PONG : llap_pkg::ST_PING;
						end
					end
					{llap_pkg::ST_GOT, llap_pkg::ST_PING}: begin
						own_nx = llap_pkg::ST_PONG;
					end
					{llap_pkg::ST_GOT, llap_pkg::ST_PONG}: begin
						own_nx = llap_pkg::ST_PING;
					end
					{llap_pkg::ST_GOT, llap_pkg::ST_ACK}: begin
						rlen_nx = item.payload_len;
						own_nx  = llap_pkg::ST_ACKACK;
					end
					{llap_pkg::ST_ACK, llap_pkg::ST_GOT}: begin
						fl[llap_pkg::FL_RECV] = 1'b0;
						own_nx = fl[llap_pkg::FL_ID_B] ? llap_pkg::ST_PING : llap_pkg::ST_PONG;
					end
					{llap_pkg::ST_ACK, llap_pkg::ST_ACKACK}: begin
						rlen_nx = item.payload_len;
						if (fl[llap_pkg::FL_RECV] && !item.user_busy && !fl[llap_pkg::FL_FULL]) begin
							fl[llap_pkg::FL_FULL] = 1'b1;
							release_i = 1'b1;
							own_nx    = llap_pkg::ST_PROCEED;
						end else begin
							own_nx = llap_pkg::ST_ACK;
						end
					end
					{llap_pkg::ST_ACKACK, llap_pkg::ST_ACK}: begin
						own_nx = llap_pkg::ST_GOT;
					end
					{llap_pkg::ST_ACKACK, llap_pkg::ST_PROCEED}: begin
						if (fl[llap_pkg::FL_SEND]) begin
							fl[llap_pkg::FL_SEND] = 1'b0;
							if (fl[llap_pkg::FL_BUSY] && !item.user_full) begin
								fl[llap_pkg::FL_BUSY] = 1'b0;
							end
						end
						rlen_nx = '0;
						own_nx = fl[llap_pkg::FL_ID_B] ? llap_pkg::ST_PING : llap_pkg::ST_PONG;
					end
					default: begin
						rsn = llap_pkg::RSN_STATE;
					end
				endcase
			end
		end
	end

	assign seq_inc = seq_nx + 1'b1;

	always_comb begin
		result             = '0;
		result.drop_reason = rsn;
		if (rsn == llap_pkg::RSN_NONE) begin
			result.transmit        = 1'b1;
			result.reply_proto     = {llap_pkg::PROTO_TAG, remote_nx, own_nx};
			result.reply_len       = rlen_nx;
			result.reply_seq       = seq_inc;
			result.reply_dst_mac   = peer_nx;
			result.load_outbound   = load;
			result.capture_inbound = capture;
			result.release_inbound = release_i;
			result.zero_payload    = (rlen_nx == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_mac_q <= '0;
			own_q      <= llap_pkg::ST_INIT;
			remote_q   <= llap_pkg::ST_INIT;
			rlen_q     <= '0;
			seq_q      <= '0;
			flags_q    <= '0;
			pay_cap_q  <= llap_pkg::PAY_CAP_RST;
		end else begin
			if (cfg_we) begin
				pay_cap_q <= cfg_data;
			end
			if (adv) begin
				peer_mac_q <= peer_nx;
				own_q      <= own_nx;
				remote_q   <= remote_nx;
				rlen_q     <= rlen_nx;
				flags_q    <= fl;
				seq_q      <= (rsn == llap_pkg::RSN_NONE) ? seq_inc : seq_nx;
			end
		end
	end

endmodule

// ===== design/link_liveness_ait_protocol.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake                  Payload
// s_axis    in   s_tvalid / s_tready        s_tdata: one received link frame
// m_axis    out  m_tvalid / m_tready        m_tdata: verdict and reply info
// cfg       in   cfg_valid / cfg_ready      cfg_data: payload cap
//
// One frame per cycle while the output is not stalled: frame is registered
// on input, decided by short combinational logic against the link state,
// and the result registered. The frame passes through the input register
// and then the result register. State commits as the item moves into the
// result register; output stalls fill both registers.
// Reset: Init/Init, flags and counters clear, payload cap 44.
module link_liveness_ait_protocol (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [47:0] dst_mac, [95:48] src_mac, [103:96] proto_byte,
	// [111:104] payload_len, [112] user_full, [113] user_busy, [119:114] zero
	input  logic [llap_pkg::IN_TDATA_W-1:0]      s_tdata,

	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] transmit, [4:1] drop_reason, [12:5] reply_proto, [20:13] reply_len,
	// [52:21] reply_seq, [100:53] reply_dst_mac, [101] load_outbound,
	// [102] capture_inbound, [103] release_inbound, [104] zero_payload,
	// [111:105] zero
	output logic [llap_pkg::OUT_TDATA_W-1:0]     m_tdata,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [llap_pkg::BYTE_W-1:0]          cfg_data
);

	localparam int ITEM_W = $bits(llap_pkg::item_t);
	localparam int RES_W  = $bits(llap_pkg::result_t);

	llap_pkg::item_t   item_s1;
	logic              valid_s1;
	llap_pkg::result_t res_s2, res_comb;
	logic              valid_s2;
	logic              adv;

	// stage 1 moves into the result register when it is empty or being drained
	assign adv       = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= llap_pkg::item_t'(s_tdata[ITEM_W-1:0]);
		end
		if (adv) begin
			res_s2 <= res_comb;
		end
	end

	llap_proto u_proto (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.adv      (adv),
		.item     (item_s1),
		.result   (res_comb)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(llap_pkg::OUT_TDATA_W - RES_W){1'b0}}, res_s2};

endmodule
